FILE: hdl/memory_access_trace_buffer_top_macros.svh
// Assertion macros for the memory access trace buffer.
`ifndef MEMORY_ACCESS_TRACE_BUFFER_TOP_MACROS_SVH
`define MEMORY_ACCESS_TRACE_BUFFER_TOP_MACROS_SVH

`ifndef SYNTH
`define MTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("trace buffer check failed");
`define MTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trace buffer check failed");
`else
`define MTB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MTB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/mtb_pkg.sv
// Types and constants shared by the trace buffer modules.
`default_nettype none
package mtb_pkg;

	localparam int DATA_W      = 32;
	localparam int MODE_W      = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH = 2'd1;

	localparam logic [DATA_W-1:0] WINDOW_LOW_RESET  = 32'h0000_0000;
	localparam logic [DATA_W-1:0] WINDOW_HIGH_RESET = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] entry_pc;
		logic [DATA_W-1:0] entry_addr;
		logic [DATA_W-1:0] entry_data;
		logic              entry_is_write;
		logic              entry_valid;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              is_write;
	} trace_entry_t;

	typedef struct packed {
		logic         is_dump;
		trace_entry_t entry;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_LOAD = 4'b0100,
		S_OUT  = 4'b1000
	} back_state_t;

endpackage
`default_nettype wire

FILE: hdl/mtb_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none
module mtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mtb_queue.sv
// Short command queue between the front and back parts.
`default_nettype none
`include "memory_access_trace_buffer_top_macros.svh"
module mtb_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire mtb_pkg::cmd_t          push_cmd,
	input  wire logic                   pop,
	output mtb_pkg::cmd_t               head_cmd,
	output mtb_pkg::queue_status_t      status
);
	import mtb_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	`MTB_ASSERT_SAME(a_no_push_when_full, clk, arst_n, push, !status.full)
	`MTB_ASSERT_SAME(a_no_pop_when_empty, clk, arst_n, pop, !status.empty)

endmodule
`default_nettype wire

FILE: hdl/mtb_front.sv
// Front part: accepts items, holds the address window and classifies items.
`default_nettype none
module mtb_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	input  wire mtb_pkg::req_t                       req,
	output logic                                     req_stall,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mtb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [mtb_pkg::DATA_W-1:0]          cfg_data,
	input  wire mtb_pkg::queue_status_t              q_status,
	output logic                                     push,
	output mtb_pkg::cmd_t                            push_cmd
);
	import mtb_pkg::*;

	logic [DATA_W-1:0] window_low_q;
	logic [DATA_W-1:0] window_high_q;
	logic              accept;
	logic              is_record;
	logic              in_window;

	assign cfg_ready = 1'b1;
	assign req_stall = q_status.full;
	assign accept    = req_valid && !q_status.full;
	assign is_record = req.mode inside {MODE_READ, MODE_WRITE};
	assign in_window = (req.addr >= window_low_q) && (req.addr <= window_high_q);

	// drop records outside the window and unused modes
	assign push = accept && ((is_record && in_window) || (req.mode == MODE_DUMP));

	assign push_cmd.is_dump        = (req.mode == MODE_DUMP);
	assign push_cmd.entry.pc       = req.pc;
	assign push_cmd.entry.addr     = req.addr;
	assign push_cmd.entry.data     = req.data;
	assign push_cmd.entry.is_write = (req.mode == MODE_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= WINDOW_LOW_RESET;
			window_high_q <= WINDOW_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LOW:  window_low_q  <= cfg_data;
				REG_WINDOW_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mtb_back.sv
// Back part: writes captures into the ring and walks it on a dump.
`default_nettype none
`include "memory_access_trace_buffer_top_macros.svh"
module mtb_back #(
	parameter int DEPTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mtb_pkg::queue_status_t q_status,
	input  wire mtb_pkg::cmd_t          head_cmd,
	output logic                        pop,
	output logic                        rsp_valid,
	output mtb_pkg::rsp_t               rsp,
	input  wire logic                   rsp_stall
);
	import mtb_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	back_state_t   state_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] rem_q;
	logic          full_q;
	logic          out_valid_q;
	rsp_t          rsp_q;
	logic          ram_wr_en;
	logic          ram_rd_en;
	trace_entry_t  ram_rd_data;
	logic [CNT_W-1:0] fill_count;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pop        = (state_q == S_IDLE) && !q_status.empty;
	assign ram_wr_en  = pop && !head_cmd.is_dump;
	assign ram_rd_en  = (state_q == S_READ);
	assign fill_count = full_q ? CNT_W'(DEPTH) : CNT_W'(wp_q);
	assign rsp_valid  = out_valid_q;
	assign rsp        = rsp_q;

	mtb_ram #(
		.WIDTH($bits(trace_entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.wr_en(ram_wr_en),
		.wr_addr(wp_q),
		.wr_data(head_cmd.entry),
		.rd_en(ram_rd_en),
		.rd_addr(rp_q),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			rem_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (!head_cmd.is_dump) begin
							wp_q <= ring_next(wp_q);
							if (wp_q == PTR_W'(DEPTH - 1)) begin
								full_q <= 1'b1;
							end
						end else if (fill_count == '0) begin
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							rp_q    <= full_q ? wp_q : '0;
							rem_q   <= fill_count;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					rp_q    <= ring_next(rp_q);
					rem_q   <= rem_q - 1'b1;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= rsp_q.last ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop && head_cmd.is_dump && fill_count == '0) begin
			rsp_q <= '{entry_pc: '0, entry_addr: '0, entry_data: '0,
				entry_is_write: 1'b0, entry_valid: 1'b0, last: 1'b1};
		end else if (state_q == S_LOAD) begin
			rsp_q.entry_pc       <= ram_rd_data.pc;
			rsp_q.entry_addr     <= ram_rd_data.addr;
			rsp_q.entry_data     <= ram_rd_data.data;
			rsp_q.entry_is_write <= ram_rd_data.is_write;
			rsp_q.entry_valid    <= 1'b1;
			rsp_q.last           <= (rem_q == '0);
		end
	end

	`MTB_ASSERT_SAME(a_valid_only_in_out, clk, arst_n, out_valid_q, state_q == S_OUT)
	`MTB_ASSERT_NEXT(a_full_sticks, clk, arst_n, full_q, full_q)
	`MTB_ASSERT_SAME(a_load_follows_read, clk, arst_n, state_q == S_LOAD,
		$past(state_q) == S_READ)
	`MTB_ASSERT_SAME(a_rem_bounded, clk, arst_n, state_q == S_READ,
		rem_q != '0 && rem_q <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

FILE: hdl/memory_access_trace_buffer_top.sv
// Top level of the memory access trace buffer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  mtb_pkg::req_t (mode, pc, addr, data)
//   rsp      out        rsp_valid/rsp_stall  mtb_pkg::rsp_t (entry fields, last)
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A record item is written from the idle state; one item a cycle while the queue has room.
// A dump starts in the idle state and passes each entry read from the ring through RAM read,
// load and hand-over states, set by the single registered RAM read port and the output register.
// Reset clears the write pointer, fill flag, queue and state and resets the window; no clearing pass.
// req_stall rises when the two-entry command queue is full; rsp_stall holds the output register.
`default_nettype none
module memory_access_trace_buffer_top #(
	parameter int DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	input  wire mtb_pkg::req_t                   req,
	output logic                                 req_stall,
	output logic                                 rsp_valid,
	output mtb_pkg::rsp_t                        rsp,
	input  wire logic                            rsp_stall,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mtb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mtb_pkg::DATA_W-1:0]      cfg_data
);
	import mtb_pkg::*;

	queue_status_t q_status;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head_cmd;

	mtb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_status(q_status),
		.push(push),
		.push_cmd(push_cmd)
	);

	mtb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head_cmd(head_cmd),
		.status(q_status)
	);

	mtb_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.head_cmd(head_cmd),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall)
	);

endmodule
`default_nettype wire

FILE: tb/sv/memory_access_trace_buffer_checker.sv
// Checker for the memory access trace buffer: watches all channels, predicts dumps, compares.
module memory_access_trace_buffer_checker #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  mtb_pkg::req_t                   req,
	input  logic                            req_stall,
	input  logic                            rsp_valid,
	input  mtb_pkg::rsp_t                   rsp,
	input  logic                            rsp_stall,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mtb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mtb_pkg::DATA_W-1:0]      cfg_data,
	output int                              fail_count,
	output int                              pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import mtb_pkg::*;

	trace_entry_t         ring_slot[DEPTH];
	bit                   slot_used[DEPTH];
	int unsigned          head_ptr;
	logic [DATA_W-1:0]    win_low;
	logic [DATA_W-1:0]    win_high;
	rsp_t                 dump_entries_due[$];
	int                   mismatch_total;

	function automatic void capture_access(req_t item);
		if (item.addr < win_low || item.addr > win_high)
			return;
		ring_slot[head_ptr].pc = item.pc;
		ring_slot[head_ptr].addr = item.addr;
		ring_slot[head_ptr].data = item.data;
		ring_slot[head_ptr].is_write = (item.mode == MODE_WRITE);
		slot_used[head_ptr] = 1'b1;
		head_ptr = (head_ptr == DEPTH - 1) ? 0 : head_ptr + 1;
	endfunction

	function automatic void expect_dump();
		int unsigned p;
		int          found;
		rsp_t        r;
		p = head_ptr;
		found = 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (slot_used[p]) begin
				r.entry_pc = ring_slot[p].pc;
				r.entry_addr = ring_slot[p].addr;
				r.entry_data = ring_slot[p].data;
				r.entry_is_write = ring_slot[p].is_write;
				r.entry_valid = 1'b1;
				r.last = 1'b0;
				dump_entries_due.push_back(r);
				found++;
			end
			p = (p == DEPTH - 1) ? 0 : p + 1;
		end
		if (found == 0) begin
			r = '0;
			r.last = 1'b1;
			dump_entries_due.push_back(r);
		end else begin
			dump_entries_due[dump_entries_due.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic void check_entry(rsp_t got);
		rsp_t want;
		if (dump_entries_due.size() == 0) begin
			mismatch_total++;
			if (mismatch_total <= 10)
				$display("%0t: unexpected entry pc=%h addr=%h data=%h wr=%b valid=%b last=%b",
					$realtime, got.entry_pc, got.entry_addr, got.entry_data,
					got.entry_is_write, got.entry_valid, got.last);
			return;
		end
		want = dump_entries_due.pop_front();
		if (got.entry_pc !== want.entry_pc || got.entry_addr !== want.entry_addr ||
				got.entry_data !== want.entry_data ||
				got.entry_is_write !== want.entry_is_write ||
				got.entry_valid !== want.entry_valid || got.last !== want.last) begin
			mismatch_total++;
			if (mismatch_total <= 10) begin
				$display("%0t: entry mismatch", $realtime);
				$display("  expected pc=%h addr=%h data=%h wr=%b valid=%b last=%b",
					want.entry_pc, want.entry_addr, want.entry_data,
					want.entry_is_write, want.entry_valid, want.last);
				$display("  actual   pc=%h addr=%h data=%h wr=%b valid=%b last=%b",
					got.entry_pc, got.entry_addr, got.entry_data,
					got.entry_is_write, got.entry_valid, got.last);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				ring_slot[i] = '0;
				slot_used[i] = 1'b0;
			end
			head_ptr = 0;
			win_low = WINDOW_LOW_RESET;
			win_high = WINDOW_HIGH_RESET;
			dump_entries_due.delete();
			mismatch_total = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				case (req.mode)
					MODE_READ, MODE_WRITE: capture_access(req);
					MODE_DUMP: expect_dump();
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_LOW: win_low = cfg_data;
					REG_WINDOW_HIGH: win_high = cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall)
				check_entry(rsp);
			fail_count <= mismatch_total;
			pending_count <= dump_entries_due.size();
		end
	end

endmodule

FILE: tb/sv/memory_access_trace_buffer_top_test.sv
// Stimulus and verdict for the memory access trace buffer.
module memory_access_trace_buffer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mtb_pkg::*;

	localparam int DEPTH         = 16;
	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 4000;

	localparam logic [MODE_W-1:0]      MODE_UNUSED  = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	req_t                   req = '0;
	logic                   req_stall;
	logic                   rsp_valid;
	rsp_t                   rsp;
	logic                   rsp_stall = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]      cfg_data = '0;
	int                     fail_count;
	int                     pending_count;

	bit                     gaps_on = 1'b1;
	bit                     hold_req = 1'b0;
	logic [DATA_W-1:0]      cur_low = WINDOW_LOW_RESET;
	logic [DATA_W-1:0]      cur_high = WINDOW_HIGH_RESET;
	int                     idle_cycles;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	memory_access_trace_buffer_top #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	memory_access_trace_buffer_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	function automatic req_t make_access(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] pc,
			logic [DATA_W-1:0] addr, logic [DATA_W-1:0] data);
		req_t r;
		r.mode = mode;
		r.pc = pc;
		r.addr = addr;
		r.data = data;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_addr();
		longint unsigned span;
		longint unsigned roll;
		if (cur_low <= cur_high && $urandom_range(0, 9) < 7) begin
			span = {32'd0, cur_high} - {32'd0, cur_low} + 1;
			roll = {32'd0, $urandom()} % span;
			case ($urandom_range(0, 5))
				0: return cur_low;
				1: return cur_high;
				default: return cur_low + roll[DATA_W-1:0];
			endcase
		end
		case ($urandom_range(0, 3))
			0: return cur_low - 1;
			1: return cur_high + 1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_req(req_t item);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_access(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] addr);
		send_req(make_access(mode, $urandom(), addr, $urandom()));
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (index == REG_WINDOW_LOW)
			cur_low = value;
		else if (index == REG_WINDOW_HIGH)
			cur_high = value;
	endtask

	task automatic set_window(logic [DATA_W-1:0] low, logic [DATA_W-1:0] high);
		drain();
		cfg_write(REG_WINDOW_LOW, low);
		cfg_write(REG_WINDOW_HIGH, high);
	endtask

	task automatic run_phase(int target, int dump_pct);
		int               useful;
		int               pick;
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] addr;
		useful = 0;
		while (useful < target) begin
			pick = $urandom_range(0, 99);
			if (pick < dump_pct)
				mode = MODE_DUMP;
			else if (pick < dump_pct + 4)
				mode = MODE_UNUSED;
			else
				mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
			addr = pick_addr();
			send_access(mode, addr);
			if (mode == MODE_DUMP)
				useful++;
			else if ((mode == MODE_READ || mode == MODE_WRITE) &&
					addr >= cur_low && addr <= cur_high)
				useful++;
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [DATA_W-1:0] base;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		send_access(MODE_DUMP, '0);
		send_access(MODE_UNUSED, $urandom());
		send_req(make_access(MODE_READ, '0, '0, '0));
		send_req(make_access(MODE_WRITE, '1, '1, '1));
		send_access(MODE_DUMP, '0);

		set_window(32'h0000_0100, 32'h0000_01FF);
		send_access(MODE_READ, 32'h0000_00FF);
		send_access(MODE_WRITE, 32'h0000_0100);
		send_access(MODE_READ, 32'h0000_01FF);
		send_access(MODE_WRITE, 32'h0000_0200);
		send_access(MODE_DUMP, '0);

		set_window(32'h0000_0300, 32'h0000_0200);
		send_access(MODE_READ, 32'h0000_0250);
		send_access(MODE_WRITE, 32'h0000_0300);
		send_access(MODE_DUMP, '0);

		drain();
		cfg_write(REG_SPARE_LO, $urandom());
		cfg_write(REG_SPARE_HI, $urandom());
		send_access(MODE_WRITE, 32'h0000_0250);
		send_access(MODE_DUMP, '0);

		set_window(32'h0000_0000, 32'hFFFF_FFFF);
		hold_req = 1'b1;
		run_phase(30, 25);

		drain();
		base = $urandom_range(0, 32'hFFFE_0000);
		set_window(base, base + $urandom_range(16, 4096));
		run_phase(80, 10);

		base = $urandom();
		set_window(base, base);
		run_phase(30, 10);

		set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_phase(20, 10);

		set_window(32'h0000_0000, 32'h0000_0000);
		run_phase(20, 10);

		set_window($urandom_range(32'h8000_0000, 32'hFFFF_FFFF),
			$urandom_range(0, 32'h7FFF_FFFF));
		run_phase(8, 30);

		set_window(32'h0000_0000, 32'hFFFF_FFFF);
		run_phase(120, 8);
		gaps_on = 1'b0;
		run_phase(55, 8);

		drain();
		if (fail_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/mtb_pkg.sv
hdl/mtb_ram.sv
hdl/mtb_queue.sv
hdl/mtb_front.sv
hdl/mtb_back.sv
hdl/memory_access_trace_buffer_top.sv
tb/sv/memory_access_trace_buffer_checker.sv
tb/sv/memory_access_trace_buffer_top_test.sv
